// ----- hw/rtl/predicted_position_exponential_search_assert.svh -----
// Assertion macros of the predicted-position search RTL, used by the controller.
`ifndef PREDICTED_POSITION_EXPONENTIAL_SEARCH_ASSERT_SVH
`define PREDICTED_POSITION_EXPONENTIAL_SEARCH_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define PPES_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define PPES_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ppes_pkg.sv -----
// Shared types, widths and codes of the predicted-position search block.
package ppes_pkg;

    // Field widths of the beats, the size register and the gallop step
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 10;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int POS_W   = 11;
    localparam int PROBE_W = 6;
    localparam int STEP_W  = 13;

    // Defaults of the top-level parameters
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_BITS    = 64;

    // Item modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   entry_index;
        logic [KEY_W-1:0]   search_key;
        logic [VAL_W-1:0]   entry_value;
        logic [IDX_W-1:0]   predicted_position;
    } t_in_beat;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   found_value;
        logic [PROBE_W-1:0] probe_total;
    } t_out_beat;

    // Source of the result beat
    typedef enum logic [1:0] {
        RES_EMPTY      = 2'd0,
        RES_HIT        = 2'd1,
        RES_MISS_FIRST = 2'd2,
        RES_MISS_BIN   = 2'd3
    } t_res_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic     wr;
        logic     start;
        logic     gal_first;
        logic     gal_next;
        logic     bin_issue;
        logic     in_bin;
        logic     finish;
        t_res_sel res_sel;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic key_eq;
        logic key_lt;
        logic key_gt;
        logic cur_zero;
        logic cur_last;
        logic size_zero;
        logic bin_ok_gal;
        logic bin_ok_bin;
        logic dir_left;
    } t_dp_stat;

endpackage

// ----- hw/rtl/ppes_dpath.sv -----
// Datapath: key/value memories, search bounds, probe counter and result register.
module ppes_dpath #(
    parameter int TABLE_DEPTH = ppes_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = ppes_pkg::DEF_KEY_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ppes_pkg::CFG_W-1:0] i_cfg_wdata,
    input  ppes_pkg::t_in_beat         i_in_data,
    input  ppes_pkg::t_dp_cmd          i_cmd,
    output ppes_pkg::t_dp_stat         o_stat,
    output ppes_pkg::t_out_beat        o_out_data
);
    import ppes_pkg::*;

    localparam int AddrW = $clog2(TABLE_DEPTH);
    localparam int unsigned PosMax = (2 ** POS_W) - 1;
    localparam int unsigned SizeCapInt =
        (TABLE_DEPTH > PosMax) ? PosMax : TABLE_DEPTH;
    localparam logic [POS_W-1:0] SizeCap = POS_W'(SizeCapInt);

    logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
    logic [VAL_W-1:0]    val_mem [TABLE_DEPTH];

    logic [CFG_W-1:0]    r_table_size;
    logic [KEY_BITS-1:0] r_key;
    logic [POS_W-1:0]    r_cur;
    logic [POS_W-1:0]    r_lo;
    logic [POS_W-1:0]    r_hi;
    logic [STEP_W-1:0]   r_step;
    logic                r_dir_left;
    logic [PROBE_W-1:0]  r_probes;
    logic [KEY_BITS-1:0] r_rd_key;
    logic [VAL_W-1:0]    r_rd_val;
    t_out_beat           r_res;

    logic [POS_W-1:0]    n_eff;
    logic [POS_W-1:0]    last;
    logic [POS_W-1:0]    pred_ext;
    logic [POS_W-1:0]    pred_clamp;
    logic                key_eq;
    logic                key_lt;
    logic                key_gt;
    logic                gal_left;
    logic [STEP_W-1:0]   gal_s;
    logic [POS_W-1:0]    gal_lo_tgt;
    logic [POS_W-1:0]    gal_hi_tgt;
    logic [POS_W-1:0]    gal_tgt;
    logic [POS_W-1:0]    pb_lo;
    logic [POS_W-1:0]    pb_hi;
    logic [POS_W-1:0]    blo;
    logic [POS_W-1:0]    bhi;
    logic [POS_W-1:0]    mid;
    logic                gal_issue;
    logic                rd_en;
    logic [POS_W-1:0]    rd_pos;
    logic [AddrW-1:0]    rd_addr;
    logic [AddrW-1:0]    wr_addr;
    logic                wr_ok;
    t_out_beat           res;

    // Clip the size register to the table depth, clamp the start slot
    assign n_eff      = (r_table_size > SizeCap) ? SizeCap : r_table_size;
    assign last       = n_eff - POS_W'(1);
    assign pred_ext   = POS_W'(i_in_data.predicted_position);
    assign pred_clamp = (pred_ext > last) ? last : pred_ext;

    // Compare the sought key with the probed entry
    assign key_eq = (r_key == r_rd_key);
    assign key_lt = (r_key < r_rd_key);
    assign key_gt = (r_key > r_rd_key);

    // Next gallop bound: step of one first, then double each time
    assign gal_left   = i_cmd.gal_first ? key_lt : r_dir_left;
    assign gal_s      = i_cmd.gal_first ? STEP_W'(1) : (r_step << 1);
    assign gal_lo_tgt = (STEP_W'(r_cur) >= gal_s) ? (r_cur - POS_W'(gal_s)) : '0;
    assign gal_hi_tgt = (STEP_W'(last - r_cur) > gal_s) ?
                        POS_W'(STEP_W'(r_cur) + gal_s) : last;
    assign gal_tgt    = gal_left ? gal_lo_tgt : gal_hi_tgt;

    // Narrow the bracket after a binary probe
    assign pb_lo = key_gt ? (r_cur + POS_W'(1)) : r_lo;
    assign pb_hi = key_gt ? r_hi : (r_cur - POS_W'(1));
    assign blo   = i_cmd.in_bin ? pb_lo : r_lo;
    assign bhi   = i_cmd.in_bin ? pb_hi : r_hi;
    assign mid   = blo + ((bhi - blo) >> 1);

    // Pick the slot to read next
    assign gal_issue = i_cmd.gal_first | i_cmd.gal_next;
    assign rd_en     = i_cmd.start | gal_issue | i_cmd.bin_issue;
    assign rd_pos    = i_cmd.start ? pred_clamp : (gal_issue ? gal_tgt : mid);
    assign rd_addr   = AddrW'(rd_pos);
    assign wr_addr   = AddrW'(i_in_data.entry_index);
    assign wr_ok     = (32'(i_in_data.entry_index) < TABLE_DEPTH);

    // Report status to the controller
    always_comb begin
        o_stat            = '0;
        o_stat.key_eq     = key_eq;
        o_stat.key_lt     = key_lt;
        o_stat.key_gt     = key_gt;
        o_stat.cur_zero   = (r_cur == '0);
        o_stat.cur_last   = (r_cur == last);
        o_stat.size_zero  = (n_eff == '0);
        o_stat.bin_ok_gal = (r_lo <= r_hi);
        o_stat.bin_ok_bin = (pb_lo <= pb_hi);
        o_stat.dir_left   = r_dir_left;
    end

    // Build the result beat
    always_comb begin
        res = '0;
        case (i_cmd.res_sel)
            RES_HIT: begin
                res.found       = 1'b1;
                res.position    = r_cur;
                res.found_value = r_rd_val;
                res.probe_total = r_probes;
            end
            RES_MISS_FIRST: begin
                res.position    = key_gt ? (r_cur + POS_W'(1)) : r_cur;
                res.probe_total = r_probes;
            end
            RES_MISS_BIN: begin
                res.position    = blo;
                res.probe_total = r_probes;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // Hold the table size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= '0;
        end else if (i_cfg_we) begin
            r_table_size <= i_cfg_wdata;
        end
    end

    // Advance the search bounds and probe count
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key    <= i_in_data.search_key[KEY_BITS-1:0];
            r_cur    <= pred_clamp;
            r_probes <= PROBE_W'(1);
        end
        if (gal_issue) begin
            r_cur    <= gal_tgt;
            r_step   <= gal_s;
            r_probes <= r_probes + PROBE_W'(1);
            if (i_cmd.gal_first) begin
                r_dir_left <= key_lt;
            end
            if (gal_left) begin
                r_lo <= gal_tgt;
                if (i_cmd.gal_first) begin
                    r_hi <= r_cur;
                end
            end else begin
                r_hi <= gal_tgt;
                if (i_cmd.gal_first) begin
                    r_lo <= r_cur;
                end
            end
        end
        if (i_cmd.bin_issue) begin
            r_lo     <= blo;
            r_hi     <= bhi;
            r_cur    <= mid;
            r_probes <= r_probes + PROBE_W'(1);
        end
        if (i_cmd.finish) begin
            r_res <= res;
        end
    end

    // Write a table entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && wr_ok) begin
            key_mem[wr_addr] <= i_in_data.search_key[KEY_BITS-1:0];
            val_mem[wr_addr] <= i_in_data.entry_value;
        end
    end

    // Read the probed entry
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_key <= key_mem[rd_addr];
            r_rd_val <= val_mem[rd_addr];
        end
    end

    assign o_out_data = r_res;

endmodule

// ----- hw/rtl/ppes_ctrl.sv -----
// Controller: search sequencer and handshake control of both channels.
`include "predicted_position_exponential_search_assert.svh"

module ppes_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_mode,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  ppes_pkg::t_dp_stat i_stat,
    output ppes_pkg::t_dp_cmd  o_cmd
);
    import ppes_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EMPTY  = 5'b00010,
        S_FIRST  = 5'b00100,
        S_GALLOP = 5'b01000,
        S_BIN    = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_acc;
    logic   out_free;
    logic   go_left;
    logic   go_right;
    logic   brk;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign go_left  = !i_stat.cur_zero && i_stat.key_lt;
    assign go_right = !i_stat.cur_last && i_stat.key_gt;
    assign brk      = i_stat.dir_left ? (i_stat.key_gt || i_stat.cur_zero)
                                      : (i_stat.key_lt || i_stat.cur_last);

    // Sequence the probes of one search
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.res_sel = RES_EMPTY;
        o_cmd.in_bin  = (r_state == S_BIN);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_mode == MODE_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else if (i_stat.size_zero) begin
                        n_state = S_EMPTY;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_FIRST;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.res_sel = RES_EMPTY;
                    n_state       = S_IDLE;
                end
            end
            S_FIRST: begin
                if (i_stat.key_eq) begin
                    if (out_free) begin
                        o_cmd.finish  = 1'b1;
                        o_cmd.res_sel = RES_HIT;
                        n_state       = S_IDLE;
                    end
                end else if (go_left || go_right) begin
                    o_cmd.gal_first = 1'b1;
                    n_state         = S_GALLOP;
                end else if (out_free) begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.res_sel = RES_MISS_FIRST;
                    n_state       = S_IDLE;
                end
            end
            S_GALLOP: begin
                if (i_stat.key_eq) begin
                    if (out_free) begin
                        o_cmd.finish  = 1'b1;
                        o_cmd.res_sel = RES_HIT;
                        n_state       = S_IDLE;
                    end
                end else if (!brk) begin
                    o_cmd.gal_next = 1'b1;
                end else if (i_stat.bin_ok_gal) begin
                    o_cmd.bin_issue = 1'b1;
                    n_state         = S_BIN;
                end else if (out_free) begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.res_sel = RES_MISS_BIN;
                    n_state       = S_IDLE;
                end
            end
            S_BIN: begin
                if (i_stat.key_eq) begin
                    if (out_free) begin
                        o_cmd.finish  = 1'b1;
                        o_cmd.res_sel = RES_HIT;
                        n_state       = S_IDLE;
                    end
                end else if (i_stat.bin_ok_bin && !(i_stat.key_lt && i_stat.cur_zero)) begin
                    o_cmd.bin_issue = 1'b1;
                end else if (out_free) begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.res_sel = RES_MISS_BIN;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold a result beat until the receiver takes it
    assign n_out_valid = o_cmd.finish || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `PPES_ASSERT_IMP(a_finish_free, i_clk, i_rst_n, o_cmd.finish, (!r_out_valid || !i_out_stall), "result loaded over an untaken beat")
    `PPES_ASSERT_NXT(a_search_start, i_clk, i_rst_n, (in_acc && i_in_mode == MODE_SEARCH && !i_stat.size_zero), (r_state == S_FIRST), "search did not start probing")
    `PPES_ASSERT_IMP(a_gallop_edge, i_clk, i_rst_n, o_cmd.gal_next, (i_stat.dir_left ? !i_stat.cur_zero : !i_stat.cur_last), "gallop stepped past the table edge")
    `PPES_ASSERT_NXT(a_probe_eval, i_clk, i_rst_n, (o_cmd.start || o_cmd.gal_first || o_cmd.gal_next || o_cmd.bin_issue), (r_state == S_FIRST || r_state == S_GALLOP || r_state == S_BIN), "probe issued with no state to evaluate it")

endmodule

// ----- hw/rtl/predicted_position_exponential_search.sv -----
// Top level of the predicted-position search block over a sorted key/value table.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes write and search beats.
//   A write beat stores key and value at entry_index.
//   A search beat starts at predicted_position (clamped to size minus one), gallops
//   with doubling steps, then bisects the bracket. Probes go one at a time through the
//   single read port of the key/value memory; a search takes about 2*log2(size)+1
//   probes, at most 22 for 1024 entries. An empty table answers with an all-zero
//   result.
//   The next beat is taken in the cycle after the result is loaded.
//   Output channel (o_out_valid / i_out_stall / o_out_data) gives one beat per search.
//   The result sits in an output register; while the receiver stalls, the next item
//   can still be accepted and searched, and its finish waits until the register frees.
//   Configuration: i_cfg_we writes i_cfg_wdata to table_size; write only when idle.
//   Reset clears table_size and the control state. Table contents are undefined
//   until written and need no clearing pass.
module predicted_position_exponential_search #(
    parameter int TABLE_DEPTH = ppes_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = ppes_pkg::DEF_KEY_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ppes_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ppes_pkg::t_in_beat         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ppes_pkg::t_out_beat        o_out_data
);
    import ppes_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequence searches and handshakes
    ppes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_mode   (i_in_data.mode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Store the table and run the probes
    ppes_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- verif/lookup_check_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the predicted-position search block: table copy, lookup predictor, checks.
package lookup_check_pkg;
    import ppes_pkg::*;

    localparam int TABLE_SLOTS = DEF_TABLE_DEPTH;
    localparam int REPORT_CAP  = 40;

    class lookup_scoreboard;
        logic [KEY_W-1:0] key_mem   [TABLE_SLOTS];
        logic [VAL_W-1:0] value_mem [TABLE_SLOTS];
        logic [CFG_W-1:0] size_reg;
        t_out_beat        pending_lookups [$];
        int               errors;
        int               checked;
        int               writes;
        int               searches;
        int               hits;
        int               empties;
        int               deepest;
        int               size_settings;

        function new();
            foreach (key_mem[i]) begin
                key_mem[i]   = '0;
                value_mem[i] = '0;
            end
            size_reg      = '0;
            errors        = 0;
            checked       = 0;
            writes        = 0;
            searches      = 0;
            hits          = 0;
            empties       = 0;
            deepest       = 0;
            size_settings = 0;
        endfunction

        function void set_size(logic [CFG_W-1:0] value);
            size_reg = value;
            size_settings++;
        endfunction

        function int pending();
            return pending_lookups.size();
        endfunction

        function t_out_beat make_result(bit hit, int unsigned pos, logic [VAL_W-1:0] val,
                                        int unsigned probes);
            t_out_beat r;
            r.found       = hit;
            r.position    = pos[POS_W-1:0];
            r.found_value = val;
            r.probe_total = probes[PROBE_W-1:0];
            return r;
        endfunction

        // Probe the predicted slot, gallop with doubling steps, then bisect the bracket
        function t_out_beat gallop_lookup(logic [KEY_W-1:0] key, int unsigned start);
            int unsigned      n;
            int unsigned      lo;
            int unsigned      hi;
            int unsigned      step;
            int unsigned      mid;
            int unsigned      probes;
            logic [KEY_W-1:0] k;
            bit               left;
            bit               right;
            n = (size_reg > TABLE_SLOTS) ? TABLE_SLOTS : size_reg;
            if (n == 0) return make_result(1'b0, 0, '0, 0);
            if (start > n - 1) start = n - 1;
            probes = 1;
            k = key_mem[start];
            if (k == key) return make_result(1'b1, start, value_mem[start], probes);
            left  = (start > 0) && (key < k);
            right = (start < n - 1) && (key > k);
            if (!left && !right) begin
                return make_result(1'b0, (key > k) ? start + 1 : start, '0, probes);
            end

            // Widen the bracket until it holds the key or hits a table edge
            lo   = start;
            hi   = start;
            step = 1;
            forever begin
                if (left && lo > 0) begin
                    lo = (lo >= step) ? lo - step : 0;
                    probes++;
                    k = key_mem[lo];
                    if (k == key) return make_result(1'b1, lo, value_mem[lo], probes);
                    if (k < key) break;
                end
                if (right && hi < n - 1) begin
                    hi = (n - 1 - hi > step) ? hi + step : n - 1;
                    probes++;
                    k = key_mem[hi];
                    if (k == key) return make_result(1'b1, hi, value_mem[hi], probes);
                    if (k > key) break;
                end
                if ((left && lo == 0) || (right && hi == n - 1)) break;
                step = step << 1;
            end

            // Bisect; a miss reports the low bound as insertion point
            while (lo <= hi && hi < n) begin
                mid = lo + (hi - lo) / 2;
                probes++;
                k = key_mem[mid];
                if (k == key) return make_result(1'b1, mid, value_mem[mid], probes);
                if (k < key) begin
                    lo = mid + 1;
                end else begin
                    if (mid == 0) break;
                    hi = mid - 1;
                end
            end
            return make_result(1'b0, lo, '0, probes);
        endfunction

        // Apply a write beat, or queue the predicted answer of a search beat
        function void note_beat(t_in_beat b);
            t_out_beat r;
            if (b.mode == MODE_WRITE) begin
                key_mem[b.entry_index]   = b.search_key;
                value_mem[b.entry_index] = b.entry_value;
                writes++;
                return;
            end
            r = gallop_lookup(b.search_key, b.predicted_position);
            searches++;
            if (size_reg == 0) empties++;
            if (r.found) hits++;
            if (r.probe_total > deepest) deepest = r.probe_total;
            pending_lookups.push_back(r);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= REPORT_CAP) $display("[%0t] MISMATCH result %0d: %s", $time, checked, what);
        endtask

        // Compare one result beat with the oldest predicted answer
        task check_beat(t_out_beat got);
            t_out_beat want;
            checked++;
            if (pending_lookups.size() == 0) begin
                report_mismatch("result beat with no search waiting");
                return;
            end
            want = pending_lookups.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("found %0d, want %0d", got.found, want.found));
            if (got.position !== want.position)
                report_mismatch($sformatf("position %0d, want %0d", got.position, want.position));
            if (got.found_value !== want.found_value)
                report_mismatch($sformatf("found_value %h, want %h",
                                          got.found_value, want.found_value));
            if (got.probe_total !== want.probe_total)
                report_mismatch($sformatf("probe_total %0d, want %0d",
                                          got.probe_total, want.probe_total));
        endtask

        function void summarize();
            $display("covered %0d table writes and %0d searches over %0d table size settings",
                     writes, searches, size_settings);
            $display("%0d hits, %0d on an empty table, deepest search %0d probes, %0d mismatches",
                     hits, empties, deepest, errors);
        endfunction
    endclass

endpackage

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench top: drives table writes, size settings and searches, and checks every result.
module tb;
    import ppes_pkg::*;
    import lookup_check_pkg::*;

    localparam int DEPTH      = DEF_TABLE_DEPTH;
    localparam int SETTLE_CYC = 32;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASES     = 11;

    typedef enum int {KEEP_TABLE, SORTED_LOW, SORTED_HIGH, SORTED_TOP, SCRAMBLED} t_fill_kind;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_mode;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_beat         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_beat        o_out_data;

    lookup_scoreboard sb;
    logic [KEY_W-1:0] stim_keys [DEPTH];
    bit               sender_gaps = 1'b0;
    int               burst_left  = 0;
    int               idle_cycles = 0;
    t_stall_mode      stall_mode  = STALL_NONE;
    int               mode_left   = 0;
    int               run_left    = 0;

    // Random phases: size setting, table content and number of search or rewrite beats
    int unsigned phase_size  [PHASES] = '{1, 2, 5, 17, 33, 130, 1024, 2047, 9, 0, 3};
    t_fill_kind  phase_fill  [PHASES] = '{SORTED_LOW, SORTED_HIGH, SORTED_TOP, SORTED_LOW,
                                          SORTED_HIGH, SORTED_TOP, SORTED_LOW, KEEP_TABLE,
                                          SCRAMBLED, KEEP_TABLE, SORTED_TOP};
    int          phase_count [PHASES] = '{60, 60, 60, 60, 60, 80, 150, 60, 60, 10, 40};

    // Directed table: a duplicate pair and a key one below the top
    logic [KEY_W-1:0] demo_keys [8] = '{64'd5, 64'd10, 64'd20, 64'd20, 64'd40, 64'd50, 64'd60,
                                        64'hFFFF_FFFF_FFFF_FFFE};

    predicted_position_exponential_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Check result beats first, then note the input beat of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_beat(o_out_data);
            if (i_in_valid && !o_in_stall) sb.note_beat(i_in_data);
        end
    end

    // End the run when no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("predicted_position_exponential_search regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver back-pressure: runs of stall and no stall, density changing over time
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 2));
            mode_left  <= $urandom_range(200, 800);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (run_left != 0) begin
            run_left <= run_left - 1;
        end else begin
            case (stall_mode)
                STALL_NONE: begin
                    i_out_stall <= 1'b0;
                    run_left    <= $urandom_range(0, 15);
                end
                STALL_LIGHT: begin
                    i_out_stall <= ($urandom_range(0, 3) == 0);
                    run_left    <= $urandom_range(0, 3);
                end
                default: begin
                    i_out_stall <= 1'($urandom_range(0, 1));
                    run_left    <= $urandom_range(0, 20);
                end
            endcase
        end
    end

    // Present one beat and hold it until accepted; with sender gaps, idle between bursts
    task automatic send_beat(input t_in_beat b);
        int gap;
        if (sender_gaps && burst_left == 0) begin
            gap        = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 16);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic write_entry(input int unsigned idx, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] val);
        t_in_beat b;
        b.mode               = MODE_WRITE;
        b.entry_index        = idx[IDX_W-1:0];
        b.search_key         = key;
        b.entry_value        = val;
        b.predicted_position = IDX_W'($urandom);
        stim_keys[idx]       = key;
        send_beat(b);
    endtask

    task automatic search_for(input logic [KEY_W-1:0] key, input int unsigned pred);
        t_in_beat b;
        b.mode               = MODE_SEARCH;
        b.entry_index        = IDX_W'($urandom);
        b.search_key         = key;
        b.entry_value        = {$urandom, $urandom};
        b.predicted_position = pred[IDX_W-1:0];
        send_beat(b);
    endtask

    // Hold the sender until every search has answered
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Write the size register once the block is idle
    task automatic set_table_size(input int unsigned size);
        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size[CFG_W-1:0];
        @(posedge i_clk);
        sb.set_size(size[CFG_W-1:0]);
        i_cfg_we    <= 1'b0;
    endtask

    // Fill slots 0..n-1 with non-decreasing keys, low or high in the key range, optionally all-ones last
    task automatic load_sorted(input int unsigned n, input bit high_keys, input bit top_key);
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] gap;
        logic [KEY_W-1:0] keys [DEPTH];
        int               sh;
        int               r;
        sh = $clog2(n + 1) + (high_keys ? 2 : 0);
        k  = high_keys ? (64'h8000_0000_0000_0000 | ({$urandom, $urandom} >> 3))
                       : ({$urandom, $urandom} >> (sh + 4));
        for (int i = 0; i < n; i++) begin
            keys[i] = k;
            r = $urandom_range(0, 15);
            if (r == 0)      gap = '0;
            else if (r == 1) gap = 64'd1;
            else             gap = {$urandom, $urandom} >> sh;
            k = k + gap;
        end
        if (top_key) keys[n - 1] = '1;
        for (int i = 0; i < n; i++) write_entry(i, keys[i], {$urandom, $urandom});
    endtask

    // One random search aimed mostly at stored keys, starting near their slots
    task automatic random_search(input int unsigned n);
        int unsigned      slot;
        int unsigned      pick;
        int               p;
        logic [KEY_W-1:0] k;
        if (n == 0) begin
            search_for({$urandom, $urandom}, $urandom_range(0, DEPTH - 1));
            return;
        end
        slot = $urandom_range(0, n - 1);
        pick = $urandom_range(0, 9);
        if (pick < 5)       k = stim_keys[slot];
        else if (pick == 5) k = stim_keys[slot] + 64'd1;
        else if (pick == 6) k = stim_keys[slot] - 64'd1;
        else if (pick == 7) k = (stim_keys[0] == '0) ? '0 : stim_keys[0] - 64'd1;
        else if (pick == 8) k = (stim_keys[n - 1] == '1) ? '1 : stim_keys[n - 1] + 64'd1;
        else                k = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            p = int'(slot) + int'($urandom_range(0, 16)) - 8;
            if (p < 0) p = 0;
            if (p > DEPTH - 1) p = DEPTH - 1;
        end else if (pick < 8) begin
            p = $urandom_range(0, DEPTH - 1);
        end else if (pick == 8) begin
            p = 0;
        end else begin
            p = DEPTH - 1;
        end
        search_for(k, p);
    endtask

    // Set the size, load the table, then run searches mixed with value rewrites and writes past the table
    task automatic run_phase(input int unsigned size, input t_fill_kind fill, input int count);
        int unsigned n;
        int unsigned slot;
        n = (size > DEPTH) ? DEPTH : size;
        sender_gaps = ($urandom_range(0, 2) != 0);
        set_table_size(size);
        case (fill)
            SORTED_LOW:  load_sorted(n, 1'b0, 1'b0);
            SORTED_HIGH: load_sorted(n, 1'b1, 1'b0);
            SORTED_TOP:  load_sorted(n, 1'b1, 1'b1);
            SCRAMBLED: begin
                for (int i = 0; i < n; i++)
                    write_entry(i, {$urandom, $urandom} >> $urandom_range(0, 63),
                                {$urandom, $urandom});
            end
            default: ;
        endcase
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) drain();
            if (n != 0 && $urandom_range(0, 11) == 0) begin
                // new value under an existing key keeps the table sorted
                slot = $urandom_range(0, n - 1);
                write_entry(slot, stim_keys[slot], {$urandom, $urandom});
            end else if (n < DEPTH && $urandom_range(0, 39) == 0) begin
                // slot outside the table in use: no search may see it
                write_entry($urandom_range(n, DEPTH - 1), {$urandom, $urandom},
                            {$urandom, $urandom});
            end else begin
                random_search(n);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table right after reset
        search_for('1, DEPTH - 1);
        search_for('0, 0);

        // Small sorted table; the far slot gets written too
        write_entry(DEPTH - 1, {$urandom, $urandom}, {$urandom, $urandom});
        for (int i = 0; i < 8; i++) write_entry(i, demo_keys[i], {$urandom, $urandom});
        set_table_size(8);
        search_for(64'd40, 4);                     // hit on the first probe
        search_for(64'd5, 7);                      // gallop left to the first slot
        search_for('1, 0);                         // key past the end
        search_for(64'd0, 3);                      // key before the first entry
        search_for(64'd20, 6);                     // duplicate key
        search_for(64'd45, DEPTH - 1);             // clamped start, miss inside
        search_for(64'hFFFF_FFFF_FFFF_FFFE, 2);    // gallop right to the last slot

        // Single entry: hit, and misses on either side without a gallop
        set_table_size(1);
        search_for(64'd5, 0);
        search_for(64'd4, 9);
        search_for(64'd6, 0);

        for (int ph = 0; ph < PHASES; ph++) run_phase(phase_size[ph], phase_fill[ph],
                                                      phase_count[ph]);

        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        sb.summarize();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("predicted_position_exponential_search regression: pass");
        end else begin
            $display("predicted_position_exponential_search regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ppes_pkg.sv
hw/rtl/ppes_dpath.sv
hw/rtl/ppes_ctrl.sv
hw/rtl/predicted_position_exponential_search.sv
verif/lookup_check_pkg.sv
verif/tb.sv
